// ===== rtl/multilevel_round_robin_scheduler_macros.svh =====
// Assertion macros for the multilevel round-robin scheduler.
// Depends on nothing; expects clk and rst_n in the including module.
`ifndef MULTILEVEL_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define MULTILEVEL_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MRRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define MRRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MRRS_ASSERT_IMP(lbl, ante, cons, msg)
`define MRRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/mrrs_pkg.sv =====
// Shared types, codes and constants for the multilevel round-robin scheduler.
// No dependencies.
package mrrs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_CLASSES     = 3;
  localparam int CLS_W           = 2;

  localparam int PID_W  = 16;
  localparam int PRIO_W = 5;
  localparam int DUR_W  = 15;
  localparam int TS_W   = 8;
  localparam int ENT_W  = PID_W + PRIO_W + DUR_W;

  localparam logic [TS_W-1:0] TS_RESET = 8'd5;
  localparam logic [PID_W-1:0] PID_RESET = 16'd1;

  // class bounds on the requested priority
  localparam logic [6:0] PRIO_CLS0_MAX = 7'd10;
  localparam logic [6:0] PRIO_CLS1_MAX = 7'd20;
  localparam logic [6:0] PRIO_MAX      = 7'd30;

  localparam logic [CLS_W-1:0] CLS_0    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_1    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_2    = 2'd2;
  localparam logic [CLS_W-1:0] CLS_LAST = CLS_W'(NUM_CLASSES - 1);

  localparam logic CMD_ADMIT    = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [2:0] STATUS_ADMITTED    = 3'd0;
  localparam logic [2:0] STATUS_INVALID     = 3'd1;
  localparam logic [2:0] STATUS_PRIO_RANGE  = 3'd2;
  localparam logic [2:0] STATUS_QUEUE_FULL  = 3'd3;
  localparam logic [2:0] STATUS_DISPATCHED  = 3'd4;
  localparam logic [2:0] STATUS_IDLE        = 3'd5;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [DUR_W-1:0]  dur;
  } entry_t;

  typedef struct packed {
    logic             gt;
    logic [DUR_W-1:0] diff;
  } alu_res_t;

  function automatic logic [CLS_W-1:0] cls_next(input logic [CLS_W-1:0] c);
    return (c == CLS_LAST) ? CLS_0 : c + CLS_W'(1);
  endfunction

endpackage

// ===== rtl/mrrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrrs_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mrrs_alu.sv =====
// Shared subtract-and-compare unit: remaining duration against the quantum.
// Depends on mrrs_pkg.
module mrrs_alu (
  input  logic [mrrs_pkg::DUR_W-1:0] a,
  input  logic [mrrs_pkg::TS_W-1:0]  b,
  output mrrs_pkg::alu_res_t         res
);
  import mrrs_pkg::*;

  logic [DUR_W-1:0] b_ext;

  assign b_ext    = DUR_W'(b);
  assign res.diff = a - b_ext;
  assign res.gt   = (a > b_ext);

endmodule

// ===== rtl/multilevel_round_robin_scheduler.sv =====
// Top level of the multilevel round-robin scheduler: sequencer, queue pointers.
// Depends on mrrs_pkg, mrrs_ram, mrrs_alu and the assertion macro header.
//
// Items enter on start while busy is low and every item yields exactly one
// result, shown for a single cycle with out_valid high; the receiver cannot
// stall, so capture it in that cycle. An admit item completes at once: its
// result appears in the cycle after acceptance and busy never rises. A dispatch
// item holds busy high, and its result appears in the cycle in which busy
// falls. Busy covers a scan of the queues in round-robin order (up to three,
// as one fill count is examined per cycle) and, for a non-empty queue, a step
// in which the head entry, read through the registered port of the entry RAM,
// passes the shared subtract-and-compare unit and is written back to the tail
// when requeued. time_slice may be written only while busy is low and no result
// is pending; a value of 0 behaves as 1. The entry RAM needs no clearing after
// reset, as an entry is only read from a non-empty queue.
`include "multilevel_round_robin_scheduler_macros.svh"

module multilevel_round_robin_scheduler #(
  parameter int QUEUE_DEPTH = mrrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic signed [7:0]             in_priority_req,
  input  logic signed [15:0]            in_duration,
  input  logic                          cfg_we,
  input  logic [mrrs_pkg::TS_W-1:0]     cfg_time_slice,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [mrrs_pkg::PID_W-1:0]    out_process_id,
  output logic [mrrs_pkg::PRIO_W-1:0]   out_priority,
  output logic [mrrs_pkg::DUR_W-1:0]    out_duration,
  output logic                          out_finished
);
  import mrrs_pkg::*;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] c,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  // control state
  logic [1:0]        state_r, state_nxt;
  logic [CLS_W-1:0]  cur_r, cur_nxt;
  logic [TS_W-1:0]   visit_r, visit_nxt;
  logic [PID_W-1:0]  next_id_r, next_id_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic [CLS_W-1:0]  scan_cls_r, scan_cls_nxt;
  logic [CLS_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [PTR_W-1:0]  head_r [NUM_CLASSES];
  logic [PTR_W-1:0]  head_nxt [NUM_CLASSES];
  logic [PTR_W-1:0]  tail_r [NUM_CLASSES];
  logic [PTR_W-1:0]  tail_nxt [NUM_CLASSES];
  logic [FILL_W-1:0] fill_r [NUM_CLASSES];
  logic [FILL_W-1:0] fill_nxt [NUM_CLASSES];

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              fin_r, fin_nxt;

  // datapath
  logic [TS_W-1:0]   quantum;
  logic              adm_invalid;
  logic              adm_high;
  logic [CLS_W-1:0]  adm_cls;
  logic [CLS_W-1:0]  cls_sel;
  logic [PTR_W-1:0]  head_sel;
  logic [PTR_W-1:0]  tail_sel;
  logic [FILL_W-1:0] fill_sel;
  logic [FILL_W-1:0] fill_after;
  logic [TS_W-1:0]   visit_base;
  logic [TS_W:0]     visit_inc;
  entry_t            ent;
  entry_t            wr_ent;
  alu_res_t          alu_res;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  assign quantum = (ts_r == '0) ? TS_W'(1) : ts_r;

  // admit checks: negative priority, duration not positive, out of range
  assign adm_invalid = in_priority_req[7] | in_duration[15] | (in_duration == '0);
  assign adm_high    = (in_priority_req[6:0] > PRIO_MAX);
  assign adm_cls     = (in_priority_req[6:0] <= PRIO_CLS0_MAX) ? CLS_0 :
                       (in_priority_req[6:0] <= PRIO_CLS1_MAX) ? CLS_1 : CLS_2;

  // one class index selects the per-class pointers in every state
  assign cls_sel  = (state_r == ST_IDLE) ? adm_cls : scan_cls_r;
  assign head_sel = head_r[cls_sel];
  assign tail_sel = tail_r[cls_sel];
  assign fill_sel = fill_r[cls_sel];

  assign ent       = entry_t'(ram_rdata);
  assign ram_waddr = slot_addr(cls_sel, tail_sel);
  assign ram_raddr = slot_addr(cls_sel, head_sel);

  mrrs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RAM_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrrs_alu u_alu (
    .a   (ent.dur),
    .b   (quantum),
    .res (alu_res)
  );

  // a fresh visit starts whenever the served class differs from the current one
  assign visit_base = (scan_cls_r != cur_r) ? '0 : visit_r;
  assign visit_inc  = {1'b0, visit_base} + (TS_W+1)'(1);
  assign fill_after = alu_res.gt ? fill_sel : fill_sel - FILL_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    visit_nxt     = visit_r;
    next_id_nxt   = next_id_r;
    ts_nxt        = cfg_we ? cfg_time_slice : ts_r;
    scan_cls_nxt  = scan_cls_r;
    scan_cnt_nxt  = scan_cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STATUS_IDLE;
    pid_nxt       = '0;
    prio_nxt      = '0;
    dur_nxt       = '0;
    fin_nxt       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wr_ent        = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_ADMIT) begin
            out_valid_nxt = 1'b1;
            if (adm_invalid) begin
              status_nxt = STATUS_INVALID;
            end else begin
              // the id is spent even if the item is then refused
              pid_nxt     = next_id_r;
              next_id_nxt = next_id_r + PID_W'(1);
              if (adm_high) begin
                status_nxt = STATUS_PRIO_RANGE;
              end else if (fill_sel >= FILL_FULL) begin
                status_nxt = STATUS_QUEUE_FULL;
              end else begin
                status_nxt        = STATUS_ADMITTED;
                ram_we            = 1'b1;
                wr_ent.pid        = next_id_r;
                wr_ent.prio       = in_priority_req[PRIO_W-1:0];
                wr_ent.dur        = in_duration[DUR_W-1:0];
                tail_nxt[cls_sel] = ring_next(tail_sel);
                fill_nxt[cls_sel] = fill_sel + FILL_W'(1);
              end
            end
          end else begin
            state_nxt    = ST_SCAN;
            scan_cls_nxt = cur_r;
            scan_cnt_nxt = '0;
          end
        end
      end

      ST_SCAN: begin
        if (fill_sel != '0) begin
          // issue the head read; data is ready in the next cycle
          ram_re    = 1'b1;
          state_nxt = ST_EXEC;
        end else if (scan_cnt_r == CLS_LAST) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_IDLE;
          state_nxt     = ST_IDLE;
        end else begin
          scan_cls_nxt = cls_next(scan_cls_r);
          scan_cnt_nxt = scan_cnt_r + CLS_W'(1);
        end
      end

      ST_EXEC: begin
        out_valid_nxt     = 1'b1;
        status_nxt        = STATUS_DISPATCHED;
        pid_nxt           = ent.pid;
        prio_nxt          = ent.prio;
        dur_nxt           = ent.dur;
        fin_nxt           = ~alu_res.gt;
        head_nxt[cls_sel] = ring_next(head_sel);
        fill_nxt[cls_sel] = fill_after;
        if (alu_res.gt) begin
          // requeue with the remaining time; the slot just freed makes room
          ram_we            = 1'b1;
          wr_ent.pid        = ent.pid;
          wr_ent.prio       = ent.prio;
          wr_ent.dur        = alu_res.diff;
          tail_nxt[cls_sel] = ring_next(tail_sel);
        end
        if ((visit_inc >= {1'b0, quantum}) || (fill_after == '0)) begin
          cur_nxt   = cls_next(scan_cls_r);
          visit_nxt = '0;
        end else begin
          cur_nxt   = scan_cls_r;
          visit_nxt = visit_inc[TS_W-1:0];
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= CLS_0;
      visit_r     <= '0;
      next_id_r   <= PID_RESET;
      ts_r        <= TS_RESET;
      scan_cls_r  <= CLS_0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      visit_r     <= visit_nxt;
      next_id_r   <= next_id_nxt;
      ts_r        <= ts_nxt;
      scan_cls_r  <= scan_cls_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // result payload; qualified by out_valid
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pid_r    <= pid_nxt;
    prio_r   <= prio_nxt;
    dur_r    <= dur_nxt;
    fin_r    <= fin_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_process_id = pid_r;
  assign out_priority   = prio_r;
  assign out_duration   = dur_r;
  assign out_finished   = fin_r;

  `MRRS_ASSERT_NXT(a_accept_progress, start && !busy, out_valid || busy, "accepted item made no progress")
  `MRRS_ASSERT_NXT(a_exec_result, state_r == ST_EXEC, out_valid && (out_status == STATUS_DISPATCHED), "dispatch gave no result")
  `MRRS_ASSERT_IMP(a_result_not_busy, out_valid, !busy, "result shown while busy")
  `MRRS_ASSERT_IMP(a_fill_bound, 1'b1, (fill_r[0] <= FILL_FULL) && (fill_r[1] <= FILL_FULL) && (fill_r[2] <= FILL_FULL), "queue fill beyond depth")
  `MRRS_ASSERT_IMP(a_dispatch_dur, out_valid && (out_status == STATUS_DISPATCHED), out_duration != '0, "dispatched entry with no time left")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the multilevel round-robin scheduler: a queue model
// predicts every result, which is then compared field by field with the block.
// Depends on mrrs_pkg and the scheduler RTL only.

import mrrs_pkg::*;

typedef struct {
  logic [2:0]        status;
  logic [PID_W-1:0]  pid;
  logic [PRIO_W-1:0] prio;
  logic [DUR_W-1:0]  dur;
  logic              fin;
} sched_result_t;

typedef struct {
  logic               cmd;
  logic signed [7:0]  prio;
  logic signed [15:0] dur;
} sched_cmd_t;

// Scheduler model plus the queue of results still to come.
class sched_scoreboard;
  entry_t           ring [NUM_CLASSES][QUEUE_DEPTH_DEF];
  int               fill [NUM_CLASSES];
  int               head [NUM_CLASSES];
  int               tail [NUM_CLASSES];
  int               cur_class;
  int               visit;
  logic [PID_W-1:0] next_id;
  logic [TS_W-1:0]  slice;
  sched_result_t    awaited [$];
  int               failures;
  int               items;
  int               by_status [8];

  function new();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      fill[c] = 0;
      head[c] = 0;
      tail[c] = 0;
    end
    foreach (by_status[i]) by_status[i] = 0;
    cur_class = 0;
    visit     = 0;
    next_id   = PID_RESET;
    slice     = TS_RESET;
    failures  = 0;
    items     = 0;
  endfunction

  function void set_slice(logic [TS_W-1:0] v);
    slice = v;
  endfunction

  function void push_entry(int c, entry_t e);
    ring[c][tail[c]] = e;
    tail[c] = (tail[c] + 1) % QUEUE_DEPTH_DEF;
    fill[c]++;
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Work out the result of one accepted item and queue it.
  function void note_item(sched_cmd_t it);
    sched_result_t r;
    entry_t        e;
    int            p;
    int            d;
    int            q;
    int            c;
    bit            found;
    r.status = STATUS_IDLE;
    r.pid    = '0;
    r.prio   = '0;
    r.dur    = '0;
    r.fin    = 1'b0;
    q = (slice == 0) ? 1 : int'(slice);
    if (it.cmd == CMD_ADMIT) begin
      p = it.prio;
      d = it.dur;
      if (p < 0 || d <= 0) begin
        r.status = STATUS_INVALID;
      end else begin
        r.pid   = next_id;
        next_id = next_id + 1'b1;
        if (p > int'(PRIO_MAX)) begin
          r.status = STATUS_PRIO_RANGE;
        end else begin
          c = (p <= int'(PRIO_CLS0_MAX)) ? 0 : (p <= int'(PRIO_CLS1_MAX)) ? 1 : 2;
          if (fill[c] >= QUEUE_DEPTH_DEF) begin
            r.status = STATUS_QUEUE_FULL;
          end else begin
            e.pid  = r.pid;
            e.prio = PRIO_W'(p);
            e.dur  = DUR_W'(d);
            push_entry(c, e);
            r.status = STATUS_ADMITTED;
          end
        end
      end
    end else begin
      found = 1'b0;
      c     = cur_class;
      for (int k = 0; k < NUM_CLASSES && !found; k++) begin
        c = (cur_class + k) % NUM_CLASSES;
        if (fill[c] != 0) found = 1'b1;
      end
      if (found) begin
        if (c != cur_class) begin
          cur_class = c;
          visit     = 0;
        end
        e = ring[c][head[c]];
        head[c] = (head[c] + 1) % QUEUE_DEPTH_DEF;
        fill[c]--;
        r.status = STATUS_DISPATCHED;
        r.pid    = e.pid;
        r.prio   = e.prio;
        r.dur    = e.dur;
        if (int'(e.dur) > q) begin
          e.dur = e.dur - DUR_W'(q);
          push_entry(c, e);
        end else begin
          r.fin = 1'b1;
        end
        visit++;
        if (visit >= q || fill[c] == 0) begin
          cur_class = (c + 1) % NUM_CLASSES;
          visit     = 0;
        end
      end
    end
    awaited.push_back(r);
    items++;
    by_status[r.status]++;
  endfunction

  function void check_result(sched_result_t got);
    sched_result_t want;
    if (awaited.size() == 0) begin
      note_failure($sformatf("unexpected result: status %0d id %0d prio %0d dur %0d fin %0d",
                             got.status, got.pid, got.prio, got.dur, got.fin));
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status || got.pid !== want.pid || got.prio !== want.prio ||
        got.dur !== want.dur || got.fin !== want.fin)
      note_failure($sformatf({"mismatch: expected status %0d id %0d prio %0d dur %0d fin %0d,",
                              " got status %0d id %0d prio %0d dur %0d fin %0d"},
                             want.status, want.pid, want.prio, want.dur, want.fin,
                             got.status, got.pid, got.prio, got.dur, got.fin));
  endfunction
endclass

module testbench;

  // No item accepted and no result shown for this many cycles means the block has hung.
  localparam int IDLE_LIMIT    = 2000;
  // Settling margin after the last awaited result, before the block is touched again.
  localparam int SETTLE_CYCLES = 8;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic               in_command      = CMD_ADMIT;
  logic signed [7:0]  in_priority_req = '0;
  logic signed [15:0] in_duration     = '0;
  logic               cfg_we          = 1'b0;
  logic [TS_W-1:0]    cfg_time_slice  = TS_RESET;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [PID_W-1:0]   out_process_id;
  logic [PRIO_W-1:0]  out_priority;
  logic [DUR_W-1:0]   out_duration;
  logic               out_finished;

  sched_scoreboard sb = new();
  int idle_cycles    = 0;
  int slice_settings = 1;
  int burst_left     = 0;
  int burst_cls      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_round_robin_scheduler u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_priority_req (in_priority_req),
    .in_duration     (in_duration),
    .cfg_we          (cfg_we),
    .cfg_time_slice  (cfg_time_slice),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_process_id  (out_process_id),
    .out_priority    (out_priority),
    .out_duration    (out_duration),
    .out_finished    (out_finished)
  );

  // Monitor: sample both channels on the edge that ends the cycle. Check the
  // result first, so an item accepted on the same edge queues behind it.
  always @(posedge clk) begin
    sched_result_t got;
    sched_cmd_t    seen;
    if (rst_n) begin
      if (out_valid) begin
        got.status = out_status;
        got.pid    = out_process_id;
        got.prio   = out_priority;
        got.dur    = out_duration;
        got.fin    = out_finished;
        sb.check_result(got);
      end
      if (start && !busy) begin
        seen.cmd  = in_command;
        seen.prio = in_priority_req;
        seen.dur  = in_duration;
        sb.note_item(seen);
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Present one item and hold it until the block takes it. Leave start high so
  // the next item can follow on the very next edge.
  task automatic send(sched_cmd_t it);
    start           <= 1'b1;
    in_command      <= it.cmd;
    in_priority_req <= it.prio;
    in_duration     <= it.dur;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for the gap that n gives; a zero gap leaves start alone.
  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start, wait for every outstanding result, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram the time slice only once the block has gone quiet.
  task automatic write_slice(logic [TS_W-1:0] v);
    drain();
    cfg_we         <= 1'b1;
    cfg_time_slice <= v;
    @(posedge clk);
    sb.set_slice(v);
    cfg_we <= 1'b0;
    slice_settings++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic sched_cmd_t admit(int p, int d);
    sched_cmd_t it;
    it.cmd  = CMD_ADMIT;
    it.prio = 8'(p);
    it.dur  = 16'(d);
    return it;
  endfunction

  // The fields are ignored on a dispatch; fill them with noise anyway.
  function automatic sched_cmd_t dispatch_item();
    sched_cmd_t it;
    it.cmd  = CMD_DISPATCH;
    it.prio = 8'($urandom);
    it.dur  = 16'($urandom);
    return it;
  endfunction

  // Mostly short runs so processes finish; now and then a long one.
  function automatic int run_time();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 40);
  endfunction

  function automatic int class_prio(int cls);
    return (cls == 0) ? $urandom_range(0, 10) : cls * 10 + $urandom_range(1, 10);
  endfunction

  function automatic sched_cmd_t random_item();
    sched_cmd_t it;
    int         r;
    // Now and then pour a burst of admits into one class to fill its queue.
    if (burst_left == 0 && $urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(12, 20);
      burst_cls  = $urandom_range(0, 2);
    end
    if (burst_left > 0) begin
      burst_left--;
      return admit(class_prio(burst_cls), run_time());
    end
    r  = $urandom_range(0, 99);
    it = dispatch_item();
    if (r < 45) return it;
    it.cmd = CMD_ADMIT;
    if (r < 82) begin
      it.prio = 8'($urandom_range(0, 30));
      it.dur  = 16'(run_time());
    end else if (r < 90) begin
      // broken request: negative priority, or a run time that is not positive
      if ($urandom_range(0, 1) == 0) it.prio = {1'b1, 7'($urandom)};
      else it.dur = ($urandom_range(0, 3) == 0) ? '0 : {1'b1, 15'($urandom)};
    end else if (r < 96) begin
      it.prio = 8'($urandom_range(31, 127));
      it.dur  = {1'b0, 15'($urandom)};
    end
    return it;
  endfunction

  // Random items, with calm stretches in which the items follow back to back.
  task automatic run_random(int n);
    bit calm;
    calm = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!calm) idle_for(gap_len());
      send(random_item());
    end
  endtask

  initial begin
    sched_cmd_t directed [$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle on empty queues, broken requests, class bounds, out of
    // range, then a run of round-robin dispatches at the reset time slice.
    directed.push_back(dispatch_item());
    directed.push_back(admit(-128, 100));
    directed.push_back(admit(5, 0));
    directed.push_back(admit(5, -32768));
    directed.push_back(admit(-1, -1));
    directed.push_back(admit(0, 1));
    directed.push_back(admit(10, 32767));
    directed.push_back(admit(11, 7));
    directed.push_back(admit(20, 5));
    directed.push_back(admit(21, 12));
    directed.push_back(admit(30, 3));
    directed.push_back(admit(31, 9));
    directed.push_back(admit(127, 32767));
    repeat (9) directed.push_back(dispatch_item());
    foreach (directed[i]) send(directed[i]);
    run_random(100);

    // Zero slice behaves as one; then both extremes.
    write_slice('0);
    run_random(120);
    write_slice(TS_W'(1));
    run_random(120);
    write_slice(TS_W'(255));
    run_random(120);

    write_slice(TS_W'(2));
    run_random(120);
    write_slice(TS_W'($urandom_range(3, 254)));
    run_random(170);
    drain();

    $display("summary: %0d items checked over %0d time-slice settings",
             sb.items, slice_settings);
    $display("summary: admitted %0d, invalid %0d, out of range %0d, full %0d, dispatched %0d, idle %0d",
             sb.by_status[STATUS_ADMITTED], sb.by_status[STATUS_INVALID],
             sb.by_status[STATUS_PRIO_RANGE], sb.by_status[STATUS_QUEUE_FULL],
             sb.by_status[STATUS_DISPATCHED], sb.by_status[STATUS_IDLE]);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== multilevel_round_robin_scheduler.f =====
+incdir+rtl
rtl/mrrs_pkg.sv
rtl/mrrs_ram.sv
rtl/mrrs_alu.sv
rtl/multilevel_round_robin_scheduler.sv
bench/testbench.sv
